/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: operation codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request operands
    logic mul;       // form cross products
    logic prep;      // form num/den, start gcd
    logic gcd_step;  // step the gcd remainder division
    logic div_start; // start a quotient divide
    logic div_step;  // one restoring divide bit
    logic div_sel;   // 0: numerator / g, 1: denominator / g
    logic fin;       // store quotient into result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

/* rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: one request in, one reduced fraction out.
// Sequence: load, cross multiply, form num/den, gcd remainder steps, two quotient divides.
// One request at a time; the gcd remainders and the two quotients use the shared
// bit-serial divider.
// Reset clears controller state and output valid; datapath registers are not reset.
// Depends on rau_pkg, rau_ctrl, rau_dp.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // a_num, a_den, b_num, b_den from bit 0 up
  input  logic [4*OPERAND_WIDTH-1:0]   s_axis_tdata_i,
  // req_type
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // res_num[31:0], res_den[61:32], is_less, is_equal, is_greater, div_by_zero, pad
  output logic [71:0]                   m_axis_tdata_o
);
  import rau_pkg::*;
  localparam int unsigned OW = OPERAND_WIDTH;

  cmd_t    cmd;
  status_t sts;
  logic signed [31:0] res_num;
  logic [29:0] res_den;
  logic lt, eq, gt, dz;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  rau_dp #(.OW(OW)) u_dp (
    .clk_i, .cmd_i(cmd), .sts_o(sts),
    .req_type_i(s_axis_tuser_i),
    .a_num_i(s_axis_tdata_i[OW-1:0]),
    .a_den_i(s_axis_tdata_i[2*OW-1:OW]),
    .b_num_i(s_axis_tdata_i[3*OW-1:2*OW]),
    .b_den_i(s_axis_tdata_i[4*OW-1:3*OW]),
    .res_num_o(res_num), .res_den_o(res_den),
    .is_less_o(lt), .is_equal_o(eq), .is_greater_o(gt), .div_by_zero_o(dz)
  );

  assign m_axis_tdata_o = {6'd0, dz, gt, eq, lt, res_den, res_num};

  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot({lt, eq, gt}))
    else $error("comparison flags not one-hot");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && OW <= 16 |-> res_den != 0)
    else $error("zero denominator");
  a_dz_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && dz |-> res_num == 0 && res_den == 30'd1)
    else $error("divide by zero result not 0/1");
endmodule

/* rtl/rau_ctrl.sv */
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg.
module rau_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rau_pkg::status_t sts_i,
  output rau_pkg::cmd_t    cmd_o
);
  import rau_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && (!ov_q || out_ready_i)) state_d = ST_MUL;
      ST_MUL:  state_d = ST_PREP;
      ST_PREP: state_d = ST_GCD;
      ST_GCD:  if (sts_i.gcd_done) state_d = ST_DIVN;
      ST_DIVN: if (sts_i.div_done) state_d = ST_DIVD;
      ST_DIVD: if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE: if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ov_d       = ov_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        cmd_o.load = in_valid_i && in_ready_o;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_PREP: cmd_o.prep = 1'b1;
      ST_GCD: begin
        cmd_o.gcd_step  = !sts_i.gcd_done;
        cmd_o.div_start = sts_i.gcd_done;
      end
      ST_DIVN: begin
        // fin keeps the numerator quotient while div_start loads the denominator
        cmd_o.div_step  = !sts_i.div_done;
        cmd_o.fin       = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
      end
      ST_DIVD: begin
        cmd_o.div_sel  = 1'b1;
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.fin      = sts_i.div_done;
      end
      ST_DONE: if (!ov_q || out_ready_i) ov_d = 1'b1;
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mul, cmd_o.prep, cmd_o.gcd_step, cmd_o.div_step}))
    else $error("several datapath commands at once");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL)
    else $error("load did not start work");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("ready while busy");
endmodule

/* rtl/rau_dp.sv */
// Datapath of the rational arithmetic unit: cross multiply, gcd by
// iterated restoring division, and division by the gcd. Depends on rau_pkg.
module rau_dp #(
  parameter int unsigned OW = 16
) (
  input  logic                clk_i,
  input  rau_pkg::cmd_t       cmd_i,
  output rau_pkg::status_t    sts_o,
  input  logic [1:0]          req_type_i,
  input  logic signed [OW-1:0] a_num_i,
  input  logic signed [OW-1:0] a_den_i,
  input  logic signed [OW-1:0] b_num_i,
  input  logic signed [OW-1:0] b_den_i,
  output logic signed [31:0]  res_num_o,
  output logic [29:0]         res_den_o,
  output logic                is_less_o,
  output logic                is_equal_o,
  output logic                is_greater_o,
  output logic                div_by_zero_o
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * OW + 1;  // products and sums
  localparam int unsigned MW = 2 * OW + 1;  // magnitudes
  localparam int unsigned CW = $clog2(MW + 1);

  logic [1:0] op_q;
  logic signed [OW-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] lhs_q, rhs_q, nn_q, dd_q;
  logic signed [OW:0] adx, bdx;
  logic neg_q, err_q;
  logic [MW-1:0] x_q, y_q, g_q, mag_q, den_q;
  // shared restoring divider: quotient/remainder of dvd_q by dvs
  logic [MW-1:0] dvd_q, quo_q, rem_q, dvs;
  logic [CW-1:0] cnt_q;
  logic          rem_busy_q, dv_busy_q;
  logic [MW:0]   trial;
  logic [MW-1:0] nq_q;
  logic signed [PW-1:0] numv, denv;

  assign adx = (ad_q <= 0) ? (OW+1)'(1) : (OW+1)'(ad_q);
  assign bdx = (bd_q <= 0) ? (OW+1)'(1) : (OW+1)'(bd_q);

  // gcd uses the divider for x % y; quotient division uses it for v / g
  assign dvs   = rem_busy_q ? y_q : g_q;
  assign trial = {rem_q, dvd_q[MW-1]} - {1'b0, dvs};

  always_comb begin
    numv = '0;
    denv = '0;
    case (op_q)
      OP_ADD: begin numv = lhs_q + rhs_q; denv = dd_q; end
      OP_SUB: begin numv = lhs_q - rhs_q; denv = dd_q; end
      OP_MUL: begin numv = nn_q; denv = dd_q; end
      default: begin
        numv = lhs_q;
        denv = nn_q;
        if (bn_q == 0) begin numv = '0; denv = PW'(1); end
        else if (bn_q < 0) begin numv = -lhs_q; denv = -nn_q; end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_type_i;
      an_q <= a_num_i; ad_q <= a_den_i; bn_q <= b_num_i; bd_q <= b_den_i;
      rem_busy_q <= 1'b0;
      dv_busy_q  <= 1'b0;
    end
    if (cmd_i.mul) begin
      lhs_q <= PW'(an_q) * PW'(bdx);
      rhs_q <= PW'(bn_q) * PW'(adx);
      if (op_q == OP_DIV) nn_q <= PW'(adx) * PW'(bn_q);
      else nn_q <= PW'(an_q) * PW'(bn_q);
      dd_q  <= PW'(adx) * PW'(bdx);
    end
    if (cmd_i.prep) begin
      neg_q <= numv < 0;
      err_q <= (op_q == OP_DIV) && (bn_q == 0);
      x_q   <= MW'(numv < 0 ? -numv : numv);
      y_q   <= MW'(denv);
      den_q <= MW'(denv);
      mag_q <= MW'(numv < 0 ? -numv : numv);
    end
    if (cmd_i.gcd_step) begin
      if (!rem_busy_q) begin
        rem_busy_q <= 1'b1;
        dvd_q <= x_q; rem_q <= '0; cnt_q <= CW'(MW);
      end else if (cnt_q != 0) begin
        rem_q <= trial[MW] ? {rem_q[MW-2:0], dvd_q[MW-1]} : trial[MW-1:0];
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q - 1'b1;
      end else begin
        rem_busy_q <= 1'b0;
        x_q <= y_q;
        y_q <= rem_q;
      end
    end
    if (cmd_i.div_start) begin
      dv_busy_q <= 1'b1;
      // first start comes from the gcd, the second with the numerator fin
      if (!cmd_i.fin) begin
        g_q   <= (x_q == 0) ? MW'(1) : x_q;
        dvd_q <= mag_q;
      end else dvd_q <= den_q;
      rem_q <= '0; quo_q <= '0; cnt_q <= CW'(MW);
    end else if (cmd_i.div_step) begin
      rem_q <= trial[MW] ? {rem_q[MW-2:0], dvd_q[MW-1]} : trial[MW-1:0];
      quo_q <= {quo_q[MW-2:0], ~trial[MW]};
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.fin && !cmd_i.div_sel) nq_q <= quo_q;
    if (cmd_i.fin && cmd_i.div_sel) begin
      // store divide-by-gcd results; the second fin writes denominator
      res_num_o  <= (nq_q == 0) ? 32'sd0 : 32'(neg_q ? -nq_q : nq_q);
      res_den_o  <= (nq_q == 0) ? 30'd1 : 30'(quo_q);
      is_less_o    <= lhs_q < rhs_q;
      is_equal_o   <= lhs_q == rhs_q;
      is_greater_o <= lhs_q > rhs_q;
      div_by_zero_o <= err_q;
    end
  end

  assign sts_o.gcd_done = !rem_busy_q && (y_q == 0);
  assign sts_o.div_done = dv_busy_q && (cnt_q == 0);
endmodule

/* verif/tb_rational_arithmetic_unit.sv */
// Testbench for rational_arithmetic_unit: random and directed fraction requests,
// with results checked against an in-bench predictor of the reduced fraction.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned OW = 16;
  localparam int unsigned WDOG_LIMIT = 30000;

  typedef struct {
    op_e             op;
    logic signed [OW-1:0] a_num, a_den, b_num, b_den;
  } frac_req_t;

  typedef struct {
    logic [31:0] num;
    logic [29:0] den;
    logic        lt, eq, gt, dz;
  } frac_res_t;

  logic            clk_i, rst_ni;
  logic            s_axis_tvalid_i, s_axis_tready_o;
  logic [4*OW-1:0] s_axis_tdata_i;
  logic [1:0]      s_axis_tuser_i;
  logic            m_axis_tvalid_o, m_axis_tready_i;
  logic [71:0]     m_axis_tdata_o;

  rational_arithmetic_unit #(.OPERAND_WIDTH(OW)) dut (.*);

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  frac_req_t in_flight;
  int        idle_phase;   // 0 none, 1 sender, 2 receiver, 3 both
  int        idle_pct;     // idle percentage of the current phase
  int        fail_cnt;
  int        quiet_cycles;

  function automatic longint fix_den(logic signed [OW-1:0] d);
    return (d <= 0) ? 64'sd1 : longint'(d);
  endfunction

  function automatic frac_res_t reduce_fraction(frac_req_t r);
    frac_res_t res;
    longint an, ad, bn, bd, lhs, rhs, num, den, x, y, t, g, mag;
    an = longint'(r.a_num);
    ad = fix_den(r.a_den);
    bn = longint'(r.b_num);
    bd = fix_den(r.b_den);
    lhs = an * bd;
    rhs = bn * ad;
    res.dz = 1'b0;
    case (r.op)
      OP_ADD: begin num = lhs + rhs; den = ad * bd; end
      OP_SUB: begin num = lhs - rhs; den = ad * bd; end
      OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin
        if (bn == 0) begin
          res.dz = 1'b1;
          num = 0;
          den = 1;
        end else begin
          num = an * bd;
          den = ad * bn;
          if (den < 0) begin
            num = -num;
            den = -den;
          end
        end
      end
    endcase
    mag = (num < 0) ? -num : num;
    x = mag;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = (x == 0) ? 1 : x;
    mag = mag / g;
    den = den / g;
    if (mag == 0) den = 1;
    res.num = (num < 0) ? 32'(-mag) : 32'(mag);
    res.den = 30'(den);
    res.lt = lhs < rhs;
    res.eq = lhs == rhs;
    res.gt = lhs > rhs;
    return res;
  endfunction

  function automatic logic [OW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'(32'($urandom_range(4)) - 2);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      2: return 16'($urandom_range(40));
      3: return 16'(-$urandom_range(40));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(op_e op, int an, int ad, int bn, int bd);
    frac_req_t r;
    r.op = op;
    r.a_num = OW'(an);
    r.a_den = OW'(ad);
    r.b_num = OW'(bn);
    r.b_den = OW'(bd);
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) expected_fracs.push_back(reduce_fraction(in_flight));
      if (pending_reqs.size() > 0 &&
          !(idle_phase[0] && $urandom_range(99) < idle_pct)) begin
        in_flight = pending_reqs.pop_front();
        s_axis_tdata_i  <= {in_flight.b_den, in_flight.b_num,
                            in_flight.a_den, in_flight.a_num};
        s_axis_tuser_i  <= in_flight.op;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    frac_res_t exp_r, got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.num = m_axis_tdata_o[31:0];
        got.den = m_axis_tdata_o[61:32];
        got.lt  = m_axis_tdata_o[62];
        got.eq  = m_axis_tdata_o[63];
        got.gt  = m_axis_tdata_o[64];
        got.dz  = m_axis_tdata_o[65];
        if (expected_fracs.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d", $time,
                   $signed(got.num), got.den);
          fail_cnt++;
        end else begin
          exp_r = expected_fracs.pop_front();
          if (got.num !== exp_r.num) begin
            $display("%0t: res_num exp %0d got %0d", $time, $signed(exp_r.num),
                     $signed(got.num));
            fail_cnt++;
          end
          if (got.den !== exp_r.den) begin
            $display("%0t: res_den exp %0d got %0d", $time, exp_r.den, got.den);
            fail_cnt++;
          end
          if ({got.lt, got.eq, got.gt} !== {exp_r.lt, exp_r.eq, exp_r.gt}) begin
            $display("%0t: lt/eq/gt exp %b%b%b got %b%b%b", $time, exp_r.lt,
                     exp_r.eq, exp_r.gt, got.lt, got.eq, got.gt);
            fail_cnt++;
          end
          if (got.dz !== exp_r.dz) begin
            $display("%0t: div_by_zero exp %b got %b", $time, exp_r.dz, got.dz);
            fail_cnt++;
          end
        end
      end
      m_axis_tready_i <= !(idle_phase[1] && $urandom_range(99) < idle_pct);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fail_cnt = 0;
    quiet_cycles = 0;
    idle_phase = 0;
    idle_pct = 86;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, each op, zero numerator, negative divisor, div by zero,
    // zero and negative denominators
    add_req(OP_ADD, 32767, 1, 32767, 1);
    add_req(OP_ADD, -32768, 32767, -32768, 32767);
    add_req(OP_SUB, -32768, 1, 32767, 1);
    add_req(OP_SUB, 5, 7, 5, 7);
    add_req(OP_MUL, -32768, 1, -32768, 1);
    add_req(OP_MUL, 32767, 32767, 32767, 32767);
    add_req(OP_MUL, 0, 5, 123, 9);
    add_req(OP_DIV, 3, 4, -6, 8);
    add_req(OP_DIV, -32768, 1, -1, 32767);
    add_req(OP_DIV, 7, 3, 0, 5);
    add_req(OP_DIV, 0, 3, 0, 0);
    add_req(OP_DIV, 1, 32767, 32767, 1);
    add_req(OP_ADD, 1, 0, 1, -5);
    add_req(OP_SUB, 2, -32768, -2, 0);
    add_req(OP_ADD, 0, 0, 0, 0);
    add_req(OP_SUB, -1, 2, 1, 2);
    add_req(OP_MUL, 6, 4, 10, 15);
    add_req(OP_DIV, -32768, -1, 32767, -32768);
    add_req(OP_ADD, -1, 65535, 1, 1);

    for (int ph = 0; ph < 4; ph++) begin
      idle_phase = ph;
      idle_pct = (ph == 3) ? 24 : 86;
      for (int i = 0; i < 158; i++)
        add_req(op_e'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
      wait (pending_reqs.size() == 0 && !s_axis_tvalid_i);
    end
    wait (expected_fracs.size() == 0);
    repeat (800) @(posedge clk_i);

    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
